### hdl/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce / long-press core.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int NUM_BUTTONS = 3;
	localparam int BTN_W       = 3;   // width of every per-button bit vector
	localparam int IDX_W       = 2;
	localparam int MODE_W      = 2;
	localparam int DELAY_W     = 8;

	// item modes
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POLL  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_LONG_DELAY = 1'b0;
	localparam logic REG_ENABLE     = 1'b1;

	localparam logic [DELAY_W-1:0] LONG_DELAY_RST = 8'd62;
	localparam logic [BTN_W-1:0]   ENABLE_RST     = 3'd7;

	typedef struct packed {
		logic [BTN_W-1:0]   stable_bits;
		logic [BTN_W-1:0]   count_low;
		logic [BTN_W-1:0]   count_high;
		logic [BTN_W-1:0]   press_flags;
		logic [BTN_W-1:0]   long_flags;
		logic [BTN_W-1:0]   latch_flags;
		logic [DELAY_W-1:0] repeat_count;
		logic               all_released;
	} btn_state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BTN_W-1:0]  raw_pins;
		logic [IDX_W-1:0]  button_index;
	} item_t;

	typedef struct packed {
		logic [BTN_W-1:0] debounced_state;
		logic             release_event;
		logic             long_event;
	} result_t;

	typedef struct packed {
		logic [DELAY_W-1:0] long_delay_ticks;
		logic [BTN_W-1:0]   enabled_mask;
	} cfg_t;

endpackage

### hdl/button_debounce_long_press_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Vertical-counter debouncer with press, release and long-press events.
// ----------------------------------------------------------------------------
// An input passes the stage-1 register, then the result register on m_tvalid.
// Throughput: one item per cycle while m_tready is high; set by the single-pass
//   eval between the input stage register and the result register.
// Reset (arst_n low): pipeline empty, all debounce state and flags zero,
//   long_delay_ticks = 62, enabled_mask = 7.
module button_debounce_long_press_core (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [2:0] raw_pins, [4:3] button_index, [7:5] zero
	input  logic [1:0] s_tuser,   // [1:0] mode
	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [2:0] debounced_state, [3] release_event,
	                              // [4] long_event, [7:5] zero
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bdlp_pkg::*;

	cfg_t       cfg_q;
	btn_state_t state_q, state_nxt;
	item_t      item_s1, item_in;
	logic       valid_s1;
	result_t    res_s2, res_nxt;
	logic       valid_s2;
	logic       adv;        // result slot free this cycle
	logic       wr_en;

	// ---------------- register port ----------------
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_delay_ticks <= LONG_DELAY_RST;
			cfg_q.enabled_mask     <= ENABLE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_LONG_DELAY: cfg_q.long_delay_ticks <= pwdata[DELAY_W-1:0];
				REG_ENABLE:     cfg_q.enabled_mask     <= pwdata[BTN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LONG_DELAY: prdata = 32'(cfg_q.long_delay_ticks);
			REG_ENABLE:     prdata = 32'(cfg_q.enabled_mask);
			default:        prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// stage 1 holds one accepted transaction; it is evaluated and moves to the
	// result register whenever that register is empty or being drained, so a
	// stalled result still leaves room for one more input.
	assign adv      = ~valid_s2 | m_tready;
	assign s_tready = ~valid_s1 | adv;

	assign item_in.mode         = s_tuser;
	assign item_in.raw_pins     = s_tdata[2:0];
	assign item_in.button_index = s_tdata[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	// ---------------- evaluation ----------------
	bdlp_eval u_eval (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// debounce state commits only when the stage-1 item actually moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_s2 <= res_nxt;
		end
	end

	// ---------------- result stream ----------------
	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.long_event, res_s2.release_event,
	                   res_s2.debounced_state};

endmodule

### hdl/bdlp_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_eval
// Next-state and result logic for one item (tick, poll or clear).
// ----------------------------------------------------------------------------
module bdlp_eval (
	input  bdlp_pkg::cfg_t       cfg,
	input  bdlp_pkg::btn_state_t cur,
	input  bdlp_pkg::item_t      item,
	output bdlp_pkg::btn_state_t nxt,
	output bdlp_pkg::result_t    res
);
	import bdlp_pkg::*;

	logic [BTN_W-1:0]   pressed, diff, lo_n, hi_n, flip, st_n;
	logic [DELAY_W-1:0] rep_dec;
	logic [BTN_W-1:0]   m;
	logic               idx_ok;

	// vertical counter: a bit flips after four disagreeing samples
	always_comb begin
		pressed = ~item.raw_pins & cfg.enabled_mask;
		diff    = cur.stable_bits ^ pressed;
		lo_n    = ~(cur.count_low & diff);
		hi_n    = lo_n ^ (cur.count_high & diff);
		flip    = diff & lo_n & hi_n;
		st_n    = cur.stable_bits ^ flip;
		rep_dec = (cur.repeat_count != '0) ? cur.repeat_count - DELAY_W'(1) : '0;
	end

	assign idx_ok = (int'(item.button_index) < NUM_BUTTONS);
	assign m      = BTN_W'(1) << item.button_index;

	always_comb begin
		nxt               = cur;
		res.release_event = 1'b0;
		res.long_event    = 1'b0;
		unique case (item.mode)
			MODE_TICK: begin
				nxt.count_low   = lo_n;
				nxt.count_high  = hi_n;
				nxt.stable_bits = st_n;
				nxt.press_flags = cur.press_flags | (st_n & flip);
				if (st_n == '0) begin
					nxt.repeat_count = cfg.long_delay_ticks;
					nxt.all_released = 1'b1;
				end else begin
					nxt.repeat_count = rep_dec;
					if (rep_dec == '0 && cur.all_released) begin
						nxt.long_flags   = cur.long_flags | st_n;
						nxt.all_released = 1'b0;
					end
				end
			end
			MODE_POLL: begin
				if (idx_ok) begin
					// pending press moves to latch first
					if ((cur.press_flags & m) != '0) begin
						nxt.latch_flags = cur.latch_flags | m;
						nxt.press_flags = cur.press_flags & ~m;
					end
					if ((nxt.latch_flags & m) != '0 && (cur.stable_bits & m) == '0) begin
						res.release_event = 1'b1;
						nxt.latch_flags   = nxt.latch_flags & ~m;
					end
					if ((cur.long_flags & m) != '0) begin
						res.long_event  = 1'b1;
						nxt.long_flags  = cur.long_flags & ~m;
						nxt.press_flags = nxt.press_flags & ~m;
						nxt.latch_flags = nxt.latch_flags & ~m;
					end
				end
			end
			MODE_CLEAR: begin
				nxt.press_flags = '0;
				nxt.long_flags  = '0;
				nxt.stable_bits = '0;
				nxt.latch_flags = '0;
			end
			default: begin
			end
		endcase
		res.debounced_state = nxt.stable_bits;
	end

endmodule
